@@ src/skdc_pkg.sv @@
package skdc_pkg;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_DUTY       = 3'd1,
    EV_PAIR_EMPTY = 3'd2,
    EV_PAIR_SET   = 3'd3,
    EV_CLEARED    = 3'd4
  } skdc_event_t;

  typedef enum logic [2:0] {
    REG_SCAN_DIVIDER     = 3'd0,
    REG_LONG_PRESS_STEPS = 3'd1,
    REG_SHORT_PRESS_MAX  = 3'd2,
    REG_DUTY_MAX         = 3'd3,
    REG_DUTY_MIN_FADE    = 3'd4,
    REG_PAIR_WINDOW      = 3'd5,
    REG_HOLD_TICKS       = 3'd6,
    REG_HOLD_PERIODS     = 3'd7
  } skdc_reg_t;

  typedef struct packed {
    logic [7:0] scan_divider;
    logic [7:0] long_press_steps;
    logic [7:0] short_press_max;
    logic [6:0] duty_max;
    logic [6:0] duty_min_fade;
    logic [7:0] pair_window_ticks;
    logic [7:0] reset_hold_ticks;
    logic [3:0] reset_hold_periods;
  } skdc_cfg_t;

  typedef struct packed {
    skdc_event_t event_res;
    logic [6:0]  duty_level;
    logic        light_on;
    logic        clear_id;
    logic [31:0] report_id;
  } skdc_res_t;

endpackage

@@ src/single_key_dimmer_control.sv @@
// Single-key dimmer controller: each input transaction is one key scan tick and
// yields exactly one result transaction, registered in the output stage. After
// reset the block waits in power-up mode, where a long hold clears the pairing
// ID and any release begins normal work with short-press toggle, long-press
// fading and triple-press pairing. One tick is accepted every clock cycle unless
// the skid entry of the two-entry output stage is full; control state updates
// combinationally. The user must write configuration only while idle (unenforced).
module single_key_dimmer_control (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // key_pressed [0], stored_id [32:1], zero fill [39:33]
  input  logic [skdc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // duty_level [6:0], light_on [7], clear_id [8], report_id [40:9], zero fill [47:41]
  output logic [skdc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // event_res [2:0]
  output logic [skdc_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                                cfg_we,
  input  logic [skdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [skdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  skdc_pkg::skdc_cfg_t cfg;
  skdc_pkg::skdc_res_t step_res;
  skdc_pkg::skdc_res_t out_res;
  logic                in_accept;

  assign in_accept = in_tvalid && in_tready;

  skdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  skdc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .key_pressed (in_tdata[0]),
    .stored_id   (in_tdata[32:1]),
    .cfg         (cfg),
    .res         (step_res)
  );

  skdc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (step_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.event_res;
  assign out_tdata = {7'd0, out_res.report_id, out_res.clear_id, out_res.light_on,
                      out_res.duty_level};

`ifndef SYNTHESIS
  a_clear_is_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.clear_id) |-> (out_res.event_res == skdc_pkg::EV_CLEARED))
    else $error("clear_id without a clear event");

  a_id_only_pairing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.report_id != '0) |->
      (out_res.event_res == skdc_pkg::EV_PAIR_SET))
    else $error("report_id set outside a pairing event");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid)
    else $error("accepted transaction produced no result");
`endif

endmodule

@@ src/skdc_cfg.sv @@
module skdc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [skdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output skdc_pkg::skdc_cfg_t                cfg_o
);

  skdc_pkg::skdc_cfg_t cfg_r;
  skdc_pkg::skdc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (skdc_pkg::skdc_reg_t'(cfg_index))
        skdc_pkg::REG_SCAN_DIVIDER:     cfg_nxt.scan_divider       = cfg_wdata;
        skdc_pkg::REG_LONG_PRESS_STEPS: cfg_nxt.long_press_steps   = cfg_wdata;
        skdc_pkg::REG_SHORT_PRESS_MAX:  cfg_nxt.short_press_max    = cfg_wdata;
        skdc_pkg::REG_DUTY_MAX:         cfg_nxt.duty_max           = cfg_wdata[6:0];
        skdc_pkg::REG_DUTY_MIN_FADE:    cfg_nxt.duty_min_fade      = cfg_wdata[6:0];
        skdc_pkg::REG_PAIR_WINDOW:      cfg_nxt.pair_window_ticks  = cfg_wdata;
        skdc_pkg::REG_HOLD_TICKS:       cfg_nxt.reset_hold_ticks   = cfg_wdata;
        skdc_pkg::REG_HOLD_PERIODS:     cfg_nxt.reset_hold_periods = cfg_wdata[3:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_divider       <= 8'd4;
      cfg_r.long_press_steps   <= 8'd15;
      cfg_r.short_press_max    <= 8'd10;
      cfg_r.duty_max           <= 7'd100;
      cfg_r.duty_min_fade      <= 7'd10;
      cfg_r.pair_window_ticks  <= 8'd50;
      cfg_r.reset_hold_ticks   <= 8'd100;
      cfg_r.reset_hold_periods <= 4'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ src/skdc_core.sv @@
module skdc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                key_pressed,
  input  logic [31:0]         stored_id,
  input  skdc_pkg::skdc_cfg_t cfg,
  output skdc_pkg::skdc_res_t res
);

  localparam logic [7:0] QUICK_PRESS_TICKS = 8'd5;
  localparam logic [7:0] PAIR_PRESSES      = 8'd2;

  typedef struct packed {
    logic [7:0] scan_count;
    logic [7:0] hold_steps;
    logic       long_flag;
    logic       fade_down;
    logic       report_pending;
    logic [6:0] duty;
    logic [6:0] saved_duty;
    logic       light_state;
    logic [7:0] quick_count;
    logic [7:0] quick_debounce;
    logic       quick_done;
    logic [7:0] quick_gap;
    logic       running;
    logic [7:0] power_hold_ticks;
    logic [3:0] power_hold_periods;
    logic       clear_armed;
  } skdc_state_t;

  skdc_state_t state_r;
  skdc_state_t state_nxt;

  function automatic logic [7:0] sat8(input logic [7:0] v);
    sat8 = (v != 8'hFF) ? v + 8'd1 : v;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    res.event_res = skdc_pkg::EV_NONE;
    res.report_id = '0;
    res.clear_id  = 1'b0;

    if (state_nxt.running) begin
      if (key_pressed) begin
        state_nxt.scan_count = sat8(state_nxt.scan_count);
        if (state_nxt.scan_count > cfg.scan_divider) begin
          state_nxt.scan_count = '0;
          state_nxt.hold_steps = sat8(state_nxt.hold_steps);
          if (state_nxt.hold_steps > cfg.long_press_steps) begin
            state_nxt.long_flag = 1'b1;
            if (state_nxt.duty != '0) begin
              if (!state_nxt.fade_down) begin
                if (state_nxt.duty < cfg.duty_max) begin
                  state_nxt.duty           = state_nxt.duty + 7'd1;
                  state_nxt.saved_duty     = state_nxt.duty;
                  state_nxt.report_pending = 1'b1;
                end
              end else if (state_nxt.duty > cfg.duty_min_fade) begin
                state_nxt.duty           = state_nxt.duty - 7'd1;
                state_nxt.saved_duty     = state_nxt.duty;
                state_nxt.report_pending = 1'b1;
              end
            end
          end
        end
      end else begin
        if (!state_nxt.long_flag && state_nxt.hold_steps != '0 &&
            state_nxt.hold_steps < cfg.short_press_max) begin
          state_nxt.report_pending = 1'b1;
          if (state_nxt.duty != '0) begin
            state_nxt.saved_duty  = state_nxt.duty;
            state_nxt.duty        = '0;
            state_nxt.light_state = 1'b0;
          end else begin
            state_nxt.duty = state_nxt.saved_duty;
            if (state_nxt.duty == '0) begin
              state_nxt.duty       = cfg.duty_max;
              state_nxt.saved_duty = cfg.duty_max;
            end
            state_nxt.light_state = 1'b1;
          end
        end else if (state_nxt.long_flag) begin
          state_nxt.fade_down = !state_nxt.fade_down;
        end
        if (state_nxt.duty == '0) begin
          state_nxt.fade_down = 1'b0;
        end
        if (state_nxt.duty == cfg.duty_max) begin
          state_nxt.fade_down = 1'b1;
        end
        state_nxt.scan_count = '0;
        state_nxt.hold_steps = '0;
        state_nxt.long_flag  = 1'b0;
        if (state_nxt.report_pending) begin
          state_nxt.report_pending = 1'b0;
          res.event_res            = skdc_pkg::EV_DUTY;
        end
      end

      if (key_pressed) begin
        state_nxt.quick_gap      = '0;
        state_nxt.quick_debounce = sat8(state_nxt.quick_debounce);
        if (state_nxt.quick_debounce > QUICK_PRESS_TICKS) begin
          state_nxt.quick_debounce = '0;
          if (!state_nxt.quick_done) begin
            state_nxt.quick_done  = 1'b1;
            state_nxt.quick_count = sat8(state_nxt.quick_count);
          end
        end
      end else begin
        state_nxt.quick_debounce = '0;
        state_nxt.quick_done     = 1'b0;
        state_nxt.quick_gap      = sat8(state_nxt.quick_gap);
        if (state_nxt.quick_gap > cfg.pair_window_ticks) begin
          state_nxt.quick_gap   = '0;
          state_nxt.quick_count = '0;
        end
        if (state_nxt.quick_count > PAIR_PRESSES) begin
          state_nxt.quick_count = '0;
          res.event_res = (stored_id == '0) ? skdc_pkg::EV_PAIR_EMPTY : skdc_pkg::EV_PAIR_SET;
          res.report_id = stored_id;
        end
      end

      if (state_nxt.clear_armed) begin
        state_nxt.clear_armed = 1'b0;
        res.event_res         = skdc_pkg::EV_CLEARED;
        res.report_id         = '0;
        res.clear_id          = 1'b1;
      end
    end else begin
      if (key_pressed) begin
        state_nxt.power_hold_ticks = sat8(state_nxt.power_hold_ticks);
        if (state_nxt.power_hold_ticks > cfg.reset_hold_ticks) begin
          state_nxt.power_hold_ticks = '0;
          if (state_nxt.power_hold_periods != 4'hF) begin
            state_nxt.power_hold_periods = state_nxt.power_hold_periods + 4'd1;
          end
          if (state_nxt.power_hold_periods > cfg.reset_hold_periods) begin
            state_nxt.power_hold_periods = '0;
            state_nxt.clear_armed        = 1'b1;
            state_nxt.running            = 1'b1;
          end
        end
      end else begin
        state_nxt.running = 1'b1;
      end
    end

    res.duty_level = state_nxt.duty;
    res.light_on   = state_nxt.light_state;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/skdc_obuf.sv @@
module skdc_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  skdc_pkg::skdc_res_t in_res,
  output logic                out_valid,
  input  logic                out_ready,
  output skdc_pkg::skdc_res_t out_res
);

  skdc_pkg::skdc_res_t main_r;
  skdc_pkg::skdc_res_t main_nxt;
  skdc_pkg::skdc_res_t skid_r;
  skdc_pkg::skdc_res_t skid_nxt;
  logic                main_vld_r;
  logic                main_vld_nxt;
  logic                skid_vld_r;
  logic                skid_vld_nxt;
  logic                take;

  assign in_ready = !skid_vld_r;
  assign take     = main_vld_r && out_ready;

  always_comb begin
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (take) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (in_valid) begin
      if (!main_vld_r || take) begin
        main_nxt     = in_res;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = in_res;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_vld_r;
  assign out_res   = main_r;

endmodule
